### hdl/lintmc_pkg.sv
// types and constants shared by the lin transceiver mode controller
// no dependencies; compiled first
`timescale 1ns / 1ps

package lintmc_pkg;

    // supply thresholds and register map
    localparam int unsigned MV_W          = 16;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam logic [MV_W-1:0] POR_RELEASE_RST = 16'd5500;
    localparam logic [MV_W-1:0] POR_ENTER_RST   = 16'd4000;

    localparam logic [CFG_IDX_W-1:0] REG_POR_RELEASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POR_ENTER   = 1'd1;

    // event kinds
    localparam logic [1:0] CMD_CS   = 2'd0;
    localparam logic [1:0] CMD_TXD  = 2'd1;
    localparam logic [1:0] CMD_BUS  = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    // transceiver modes
    localparam logic [2:0] MODE_POR   = 3'd0;
    localparam logic [2:0] MODE_READY = 3'd1;
    localparam logic [2:0] MODE_OPER  = 3'd2;
    localparam logic [2:0] MODE_TOFF  = 3'd3;
    localparam logic [2:0] MODE_PDOWN = 3'd4;

    // bus pin drive
    localparam logic [1:0] DRV_RELEASED = 2'd0;
    localparam logic [1:0] DRV_PULLUP   = 2'd1;
    localparam logic [1:0] DRV_DOMINANT = 2'd2;

    typedef struct packed {
        logic [1:0]      command;
        logic            cs_level;
        logic            txd_level;
        logic            bus_level;
        logic            rxd_level;
        logic [MV_W-1:0] vbb_mv;
    } item_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] bus_drive;
        logic       rxd_low;
        logic       vren_on;
        logic       fault;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [MV_W-1:0]      wdata;
    } cfg_t;

    typedef struct packed {
        logic [2:0] op_mode;
        logic       fault_seen;
        logic [1:0] bus_drive_held;
        logic       rxd_drive_held;
        logic       vren_drive_held;
    } state_t;

endpackage

### hdl/lintmc_if.sv
// valid/ready channel interfaces for items, results and register writes
// depends on lintmc_pkg
`timescale 1ns / 1ps

interface lintmc_item_if;
    logic                 valid;
    logic                 ready;
    lintmc_pkg::item_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lintmc_result_if;
    logic                 valid;
    logic                 ready;
    lintmc_pkg::result_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lintmc_cfg_if;
    logic                 valid;
    logic                 ready;
    lintmc_pkg::cfg_t     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/lintmc_step.sv
// next-state logic: applies one event to the mode and pin drive state
// depends on lintmc_pkg
`timescale 1ns / 1ps

module lintmc_step (
    input  lintmc_pkg::state_t                  cur,
    input  lintmc_pkg::item_t                   item,
    input  logic [lintmc_pkg::MV_W-1:0]         por_release_mv,
    input  logic [lintmc_pkg::MV_W-1:0]         por_enter_mv,
    output lintmc_pkg::state_t                  nxt
);
    import lintmc_pkg::*;

    // pin drives from the mode, plus the receive line monitor
    function automatic state_t recompute(state_t s_in, logic txd, logic bus, logic rxd);
        state_t s;
        logic   rx_on;
        logic   bus_recessive;
        s        = s_in;
        rx_on    = (s.op_mode == MODE_READY) || (s.op_mode == MODE_OPER) ||
                   (s.op_mode == MODE_TOFF);
        if (s.op_mode == MODE_OPER)
            s.bus_drive_held = txd ? DRV_PULLUP : DRV_DOMINANT;
        else
            s.bus_drive_held = DRV_RELEASED;
        bus_recessive = (s.bus_drive_held != DRV_DOMINANT) && bus;
        if (rx_on && !bus_recessive)
        begin
            s.rxd_drive_held = 1'b1;
        end
        else
        begin
            s.rxd_drive_held = 1'b0;
            if (rx_on && !rxd)
            begin
                s.fault_seen = 1'b1;
                if (s.op_mode == MODE_OPER)
                begin
                    s.op_mode        = MODE_TOFF;
                    s.bus_drive_held = DRV_RELEASED;
                end
            end
        end
        s.vren_drive_held = !((s.op_mode == MODE_POR) || (s.op_mode == MODE_PDOWN));
        return s;
    endfunction

    state_t     mid;
    logic       do_recompute;
    logic [2:0] cs_mode;

    // mode picked by chip select / power-up from the pin levels
    assign cs_mode = item.txd_level ? MODE_OPER : MODE_TOFF;

    always_comb
    begin
        mid          = cur;
        do_recompute = 1'b0;
        unique case (item.command)
            CMD_CS:
            begin
                if (cur.op_mode != MODE_POR)
                begin
                    if (item.cs_level)
                        mid.op_mode = cs_mode;
                    else if (cur.op_mode != MODE_READY)
                        mid.op_mode = MODE_PDOWN;
                    do_recompute = 1'b1;
                end
            end
            CMD_TXD:
            begin
                // recovery from transmitter-off clears the fault
                if (cur.op_mode == MODE_TOFF && item.txd_level && item.cs_level)
                begin
                    mid.fault_seen = 1'b0;
                    mid.op_mode    = MODE_OPER;
                end
                do_recompute = 1'b1;
            end
            CMD_BUS:
            begin
                do_recompute = 1'b1;
            end
            CMD_TICK:
            begin
                if (cur.op_mode == MODE_POR)
                begin
                    if (item.vbb_mv > por_release_mv)
                    begin
                        mid.op_mode  = item.cs_level ? cs_mode : MODE_READY;
                        do_recompute = 1'b1;
                    end
                end
                else if (item.vbb_mv < por_enter_mv)
                begin
                    mid.op_mode  = MODE_POR;
                    do_recompute = 1'b1;
                end
            end
            default:
            begin
                do_recompute = 1'b0;
            end
        endcase
    end

    assign nxt = do_recompute ?
                 recompute(mid, item.txd_level, item.bus_level, item.rxd_level) : mid;

endmodule

### hdl/lin_transceiver_mode_control.sv
// top level of the lin transceiver mode controller
// depends on lintmc_pkg, lintmc_if and lintmc_step
`timescale 1ns / 1ps

// channel   | role   | payload
// ----------+--------+----------------------------------------------------
// item      | sink   | command, cs/txd/bus/rxd levels, vbb_mv
// result    | source | mode, bus_drive, rxd_low, vren_on, fault
// cfg       | sink   | index (0 por_release_mv, 1 por_enter_mv), wdata
//
// an item is registered on acceptance, then applied to the mode state once the
// result register is free, which writes the result register; one item per cycle
// sustained while result.ready stays high
// rst_n puts the mode state in power-on reset, loads the default thresholds
// (5500 and 4000 mv) and clears both valid flags
// a stalled result holds the whole pipe; item.ready drops only while both
// the input register and the result register are full and result.ready is low
// cfg.ready is always high

module lin_transceiver_mode_control (
    input  logic            clk,
    input  logic            rst_n,
    lintmc_item_if.sink     item,
    lintmc_result_if.source result,
    lintmc_cfg_if.sink      cfg
);
    import lintmc_pkg::*;

    // threshold registers
    logic [MV_W-1:0] por_release_reg;
    logic [MV_W-1:0] por_enter_reg;

    // input register
    logic            in_valid_reg;
    item_t           in_item_reg;

    // mode and held drives
    state_t          state_reg;
    state_t          state_next;

    // result register
    logic            out_valid_reg;
    result_t         out_result_reg;

    logic            out_free;
    logic            advance;
    logic            in_take;

    // the result register can load when empty or being drained
    assign out_free = !out_valid_reg || result.ready;
    assign advance  = in_valid_reg && out_free;
    assign in_take  = item.valid && item.ready;

    assign item.ready  = !in_valid_reg || out_free;
    assign cfg.ready   = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_result_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            por_release_reg <= POR_RELEASE_RST;
            por_enter_reg   <= POR_ENTER_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_POR_RELEASE: por_release_reg <= cfg.data.wdata;
                REG_POR_ENTER:   por_enter_reg   <= cfg.data.wdata;
                default:         por_enter_reg   <= por_enter_reg;
            endcase
        end
    end

    // event decode and drive recompute
    lintmc_step u_step (
        .cur            (state_reg),
        .item           (in_item_reg),
        .por_release_mv (por_release_reg),
        .por_enter_mv   (por_enter_reg),
        .nxt            (state_next)
    );

    // control: valid flags and mode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{op_mode: MODE_POR, fault_seen: 1'b0,
                               bus_drive_held: DRV_RELEASED, rxd_drive_held: 1'b0,
                               vren_drive_held: 1'b0};
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= item.data;
        if (advance)
        begin
            out_result_reg.mode      <= state_next.op_mode;
            out_result_reg.bus_drive <= state_next.bus_drive_held;
            out_result_reg.rxd_low   <= state_next.rxd_drive_held;
            out_result_reg.vren_on   <= state_next.vren_drive_held;
            out_result_reg.fault     <= state_next.fault_seen;
        end
    end

endmodule

### bench/testbench.sv
// self-checking testbench for the lin transceiver mode controller
// depends on lintmc_pkg, the lintmc channel interfaces and lin_transceiver_mode_control
`timescale 1ns / 1ps

module testbench;
    import lintmc_pkg::*;

    // cycles without any handshake before the run is declared hung
    localparam int unsigned STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;

    lintmc_item_if   item_ch ();
    lintmc_result_if result_ch ();
    lintmc_cfg_if    cfg_ch ();

    lin_transceiver_mode_control dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // 10 ns clock, low for the first half period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // idle percentages of the item sender and the result receiver
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // shadow of the transceiver state, advanced once per accepted item
    logic [2:0]      mode_q;
    logic            fault_q;
    logic [1:0]      bus_q;
    logic            rxd_q;
    logic            vren_q;
    logic [MV_W-1:0] release_mv;
    logic [MV_W-1:0] enter_mv;

    // pin states still owed by the block, oldest first
    result_t expected_pins[$];
    int unsigned mismatches;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // pin drives from the current mode; the receive monitor may force
    // transmitter-off when the line reads low on a recessive bus
    function automatic void refresh_drives(logic txd, logic bus, logic rxd);
        logic rx_on;
        logic bus_recessive;
        rx_on = (mode_q == MODE_READY) || (mode_q == MODE_OPER) || (mode_q == MODE_TOFF);
        if (mode_q == MODE_OPER)
            bus_q = txd ? DRV_PULLUP : DRV_DOMINANT;
        else
            bus_q = DRV_RELEASED;
        bus_recessive = (bus_q != DRV_DOMINANT) && bus;
        if (rx_on && !bus_recessive)
            rxd_q = 1'b1;
        else
        begin
            rxd_q = 1'b0;
            if (rx_on && bus_recessive && !rxd)
            begin
                fault_q = 1'b1;
                if (mode_q == MODE_OPER)
                begin
                    mode_q = MODE_TOFF;
                    bus_q  = DRV_RELEASED;
                end
            end
        end
        vren_q = !((mode_q == MODE_POR) || (mode_q == MODE_PDOWN));
    endfunction

    // apply one pin event to the shadow state, return the pin state it leaves
    function automatic result_t next_pin_state(item_t ev);
        result_t r;
        case (ev.command)
            CMD_CS:
            begin
                // chip select is ignored while in power-on reset
                if (mode_q != MODE_POR)
                begin
                    if (ev.cs_level)
                        mode_q = ev.txd_level ? MODE_OPER : MODE_TOFF;
                    else if (mode_q != MODE_READY)
                        mode_q = MODE_PDOWN;
                    refresh_drives(ev.txd_level, ev.bus_level, ev.rxd_level);
                end
            end
            CMD_TXD:
            begin
                // recovery from transmitter-off needs both txd and cs high
                if (mode_q == MODE_TOFF && ev.txd_level && ev.cs_level)
                begin
                    fault_q = 1'b0;
                    mode_q  = MODE_OPER;
                end
                refresh_drives(ev.txd_level, ev.bus_level, ev.rxd_level);
            end
            CMD_BUS:
                refresh_drives(ev.txd_level, ev.bus_level, ev.rxd_level);
            default:
            begin
                // supervisor tick: strict compares against both thresholds
                if (mode_q == MODE_POR)
                begin
                    if (ev.vbb_mv > release_mv)
                    begin
                        if (ev.cs_level)
                            mode_q = ev.txd_level ? MODE_OPER : MODE_TOFF;
                        else
                            mode_q = MODE_READY;
                        refresh_drives(ev.txd_level, ev.bus_level, ev.rxd_level);
                    end
                end
                else if (ev.vbb_mv < enter_mv)
                begin
                    mode_q = MODE_POR;
                    refresh_drives(ev.txd_level, ev.bus_level, ev.rxd_level);
                end
            end
        endcase
        r.mode      = mode_q;
        r.bus_drive = bus_q;
        r.rxd_low   = rxd_q;
        r.vren_on   = vren_q;
        r.fault     = fault_q;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // channel drivers; every task is entered and left just after a falling edge
    // ---------------------------------------------------------------

    function automatic item_t pin_event(logic [1:0] cmd, logic cs, logic txd, logic bus,
                                        logic rxd, logic [MV_W-1:0] vbb);
        item_t ev;
        ev.command   = cmd;
        ev.cs_level  = cs;
        ev.txd_level = txd;
        ev.bus_level = bus;
        ev.rxd_level = rxd;
        ev.vbb_mv    = vbb;
        return ev;
    endfunction

    // offer one item, predict its pin state when it is accepted
    task automatic send_event(item_t ev);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid = 1'b1;
        item_ch.data  = ev;
        do
            @(posedge clk);
        while (!item_ch.ready);
        expected_pins.push_back(next_pin_state(ev));
        @(negedge clk);
    endtask

    // hold off until every owed pin state has come back
    task automatic wait_drained();
        item_ch.valid = 1'b0;
        while (expected_pins.size() != 0)
            @(negedge clk);
        // extra margin before moving on
        repeat (4) @(negedge clk);
    endtask

    task automatic write_threshold(logic [CFG_IDX_W-1:0] idx, logic [MV_W-1:0] value);
        cfg_ch.valid      = 1'b1;
        cfg_ch.data.index = idx;
        cfg_ch.data.wdata = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_POR_RELEASE)
            release_mv = value;
        else
            enter_mv = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_thresholds(logic [MV_W-1:0] rel, logic [MV_W-1:0] ent);
        wait_drained();
        write_threshold(REG_POR_RELEASE, rel);
        write_threshold(REG_POR_ENTER, ent);
    endtask

    // supply level: mostly around the thresholds, sometimes the rails or anywhere
    function automatic logic [MV_W-1:0] pick_supply();
        int unsigned sel;
        int          lvl;
        sel = $urandom_range(9);
        if (sel < 3)
            lvl = int'(release_mv) + int'($urandom_range(6)) - 3;
        else if (sel < 6)
            lvl = int'(enter_mv) + int'($urandom_range(6)) - 3;
        else if (sel == 6)
            lvl = 0;
        else if (sel == 7)
            lvl = 65535;
        else
            lvl = int'($urandom_range(65535));
        if (lvl < 0)
            lvl = 0;
        if (lvl > 65535)
            lvl = 65535;
        return lvl[MV_W-1:0];
    endfunction

    // mostly plausible pin traffic; the receive line reads low now and then to
    // exercise the monitor, ticks come often enough to leave and reenter reset
    function automatic item_t random_event();
        int unsigned w;
        logic [1:0]  cmd;
        w = $urandom_range(99);
        if (w < 25)
            cmd = CMD_CS;
        else if (w < 55)
            cmd = CMD_TXD;
        else if (w < 75)
            cmd = CMD_BUS;
        else
            cmd = CMD_TICK;
        return pin_event(cmd, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), $urandom_range(99) < 75, pick_supply());
    endfunction

    // ---------------------------------------------------------------
    // result receiver and checker
    // ---------------------------------------------------------------

    always @(negedge clk)
        result_ch.ready = ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (expected_pins.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result ", $realtime,
                             "mode=%0d bus=%0d rxd_low=%0b vren=%0b fault=%0b",
                             got.mode, got.bus_drive, got.rxd_low, got.vren_on,
                             got.fault);
            end
            else
            begin
                want = expected_pins.pop_front();
                if (got.mode !== want.mode || got.bus_drive !== want.bus_drive ||
                    got.rxd_low !== want.rxd_low || got.vren_on !== want.vren_on ||
                    got.fault !== want.fault)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch ", $realtime,
                                 "exp mode=%0d bus=%0d rxd_low=%0b vren=%0b fault=%0b, ",
                                 want.mode, want.bus_drive, want.rxd_low,
                                 want.vren_on, want.fault,
                                 "got mode=%0d bus=%0d rxd_low=%0b vren=%0b fault=%0b",
                                 got.mode, got.bus_drive,
                                 got.rxd_low, got.vren_on, got.fault);
                end
            end
        end
    end

    // watchdog: any handshake on any channel restarts the count
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // walk the mode graph by hand: ignored chip select in reset, exact
    // threshold compares, dominant drive, monitor fault and its recovery,
    // power down, ready holding on cs low, supply rails
    task automatic test_mode_walk();
        send_event(pin_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
        send_event(pin_event(CMD_CS,   1'b1, 1'b1, 1'b1, 1'b1, 16'hffff));
        send_event(pin_event(CMD_TXD,  1'b1, 1'b1, 1'b0, 1'b0, 16'd0));
        // equal to the release level does not leave reset
        send_event(pin_event(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 16'd5500));
        send_event(pin_event(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 16'd5501));
        // txd low drives the bus dominant, the receiver echoes it
        send_event(pin_event(CMD_TXD,  1'b1, 1'b0, 1'b1, 1'b1, 16'd0));
        send_event(pin_event(CMD_BUS,  1'b1, 1'b1, 1'b0, 1'b1, 16'd0));
        // receive line low on a recessive bus trips the monitor
        send_event(pin_event(CMD_BUS,  1'b1, 1'b1, 1'b1, 1'b0, 16'd0));
        // no recovery while cs is low
        send_event(pin_event(CMD_TXD,  1'b0, 1'b1, 1'b1, 1'b1, 16'd0));
        send_event(pin_event(CMD_TXD,  1'b1, 1'b1, 1'b1, 1'b1, 16'd0));
        send_event(pin_event(CMD_CS,   1'b0, 1'b1, 1'b1, 1'b1, 16'd0));
        // equal to the enter level does not enter reset
        send_event(pin_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 16'd4000));
        send_event(pin_event(CMD_CS,   1'b1, 1'b0, 1'b1, 1'b1, 16'd0));
        send_event(pin_event(CMD_TICK, 1'b1, 1'b0, 1'b1, 1'b1, 16'd3999));
        send_event(pin_event(CMD_TICK, 1'b0, 1'b1, 1'b1, 1'b1, 16'hffff));
        // ready stays ready on cs low
        send_event(pin_event(CMD_CS,   1'b0, 1'b0, 1'b0, 1'b1, 16'd0));
        send_event(pin_event(CMD_BUS,  1'b0, 1'b0, 1'b1, 1'b0, 16'd0));
        send_event(pin_event(CMD_CS,   1'b1, 1'b0, 1'b1, 1'b1, 16'd0));
        send_event(pin_event(CMD_TICK, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0));
        send_event(pin_event(CMD_TICK, 1'b1, 1'b0, 1'b0, 1'b1, 16'hffff));
        // a quiet tick keeps the held drives
        send_event(pin_event(CMD_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 16'hffff));
        send_event(pin_event(CMD_TXD,  1'b1, 1'b1, 1'b0, 1'b1, 16'haaaa));
        send_event(pin_event(CMD_BUS,  1'b1, 1'b0, 1'b1, 1'b0, 16'h5555));
    endtask

    // threshold extremes: never leave reset and never reenter it, the reverse
    // setting, and both registers at the same rail
    task automatic test_threshold_extremes(int unsigned per_setting);
        logic [MV_W-1:0] rel_set[4];
        logic [MV_W-1:0] ent_set[4];
        rel_set = '{16'hffff, 16'd0, 16'd0, 16'hffff};
        ent_set = '{16'd0, 16'hffff, 16'd0, 16'hffff};
        for (int s = 0; s < 4; s++)
        begin
            set_thresholds(rel_set[s], ent_set[s]);
            repeat (per_setting) send_event(random_event());
        end
    endtask

    task automatic test_random_traffic(int unsigned count);
        repeat (count) send_event(random_event());
    endtask

    initial
    begin
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.data      = '0;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        send_idle_pct     = 29;
        recv_idle_pct     = 74;
        mismatches        = 0;
        mode_q            = MODE_POR;
        fault_q           = 1'b0;
        bus_q             = DRV_RELEASED;
        rxd_q             = 1'b0;
        vren_q            = 1'b0;
        release_mv        = POR_RELEASE_RST;
        enter_mv          = POR_ENTER_RST;

        // reset held from time zero, released on a falling edge
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // sender lightly idle, receiver heavily stalled
        test_mode_walk();
        test_threshold_extremes(40);
        set_thresholds(POR_RELEASE_RST, POR_ENTER_RST);
        test_random_traffic(450);

        // roles swapped, thresholds moved to random mid-range levels
        send_idle_pct = 74;
        recv_idle_pct = 29;
        set_thresholds(16'($urandom_range(7000, 3000)), 16'($urandom_range(7000, 3000)));
        test_random_traffic(450);

        // full rate both ways, back at the reset thresholds
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_thresholds(POR_RELEASE_RST, POR_ENTER_RST);
        test_random_traffic(450);

        wait_drained();
        if (mismatches == 0 && expected_pins.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
